>>> design/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types and constants for the range prime finder: payload structs,
// controller to datapath command and status groups, widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rpf_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int MAX_SPAN    = 128;
   localparam int RESULT_CAP  = 32;

   localparam int SQ_WIDTH    = 2 * VALUE_WIDTH;
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
   localparam int COUNT_WIDTH = $clog2(RESULT_CAP + 1);

   localparam logic [VALUE_WIDTH:0]     SPAN_EXT      = (VALUE_WIDTH + 1)'(MAX_SPAN);
   localparam logic [VALUE_WIDTH-1:0]   FIRST_PRIME   = VALUE_WIDTH'(2);
   localparam logic [SQ_WIDTH-1:0]      FIRST_SQUARE  = SQ_WIDTH'(4);
   localparam logic [STEP_WIDTH-1:0]    LAST_STEP     = STEP_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [COUNT_WIDTH-1:0]   CAP_COUNT     = COUNT_WIDTH'(RESULT_CAP);

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] range_start;
      logic [VALUE_WIDTH-1:0] range_end;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] prime_value;
      logic                   found;
      logic                   last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_range;
      logic next_cand;
      logic div_start;
      logic div_step;
      logic next_div;
      logic hold_prime;
      logic emit;
      logic emit_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cand_in_range;
      logic cap_reached;
      logic cand_small;
      logic sq_gt_cand;
      logic div_last;
      logic rem_zero;
      logic any_found;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> design/rpf_ctrl.sv
// ----------------------------------------------------------------------------
// rpf_ctrl
// Sequencer for the prime search: walks candidates, runs the trial
// division loop and schedules result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rpf_pkg::sts_type sts,
   output rpf_pkg::cmd_type      cmd
);
   import rpf_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_TEST   = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_JUDGE  = 7'b0010000,
      ST_PRIME  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_range = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!sts.cand_in_range || sts.cap_reached) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sts.cand_small) begin
               cmd.next_cand = 1'b1;
               state_in      = ST_CHECK;
            end else if (sts.sq_gt_cand) begin
               state_in = ST_PRIME;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (sts.rem_zero) begin
               cmd.next_cand = 1'b1;
               state_in      = ST_CHECK;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_TEST;
            end
         end
         ST_PRIME: begin
            // the previous prime goes out only now that a later one exists
            if (!sts.any_found) begin
               cmd.hold_prime = 1'b1;
               cmd.next_cand  = 1'b1;
               state_in       = ST_CHECK;
            end else if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.hold_prime = 1'b1;
               cmd.next_cand  = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/rpf_datapath.sv
// ----------------------------------------------------------------------------
// rpf_datapath
// Candidate and divisor registers, running divisor square, bit-serial
// remainder unit, pending prime holder and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rpf_pkg::req_type req_payload,
   input  wire rpf_pkg::cmd_type cmd,
   output rpf_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rpf_pkg::rsp_type      rsp_payload
);
   import rpf_pkg::*;

   logic [VALUE_WIDTH-1:0] cand_ff, cand_in;
   logic [VALUE_WIDTH-1:0] limit_ff, limit_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [SQ_WIDTH-1:0]    sq_ff, sq_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [VALUE_WIDTH-1:0] pending_ff, pending_in;
   logic                   any_found_ff, any_found_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [VALUE_WIDTH:0]   span_end;
   logic [VALUE_WIDTH:0]   trial;
   logic                   trial_ge;

   // clip the end to start plus the span
   assign span_end = {1'b0, req_payload.range_start} + SPAN_EXT;

   // one restoring-division step, remainder only
   assign trial    = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});

   always_comb begin
      cand_in      = cand_ff;
      limit_in     = limit_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      step_in      = step_ff;
      pending_in   = pending_ff;
      any_found_in = any_found_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (cmd.load_range) begin
         cand_in      = req_payload.range_start;
         any_found_in = 1'b0;
         count_in     = '0;
         if ({1'b0, req_payload.range_end} > span_end) begin
            limit_in = span_end[VALUE_WIDTH-1:0];
         end else begin
            limit_in = req_payload.range_end;
         end
      end
      if (cmd.next_cand) begin
         cand_in = cand_ff + VALUE_WIDTH'(1);
      end
      if (cmd.load_range || cmd.next_cand) begin
         div_in = FIRST_PRIME;
         sq_in  = FIRST_SQUARE;
      end
      if (cmd.next_div) begin
         // (d+1)^2 = d^2 + 2d + 1
         sq_in  = sq_ff + {{VALUE_WIDTH-1{1'b0}}, div_ff, 1'b1};
         div_in = div_ff + VALUE_WIDTH'(1);
      end
      if (cmd.div_start) begin
         rem_in  = '0;
         dvd_in  = cand_ff;
         step_in = LAST_STEP;
      end
      if (cmd.div_step) begin
         if (trial_ge) begin
            rem_in = trial[VALUE_WIDTH-1:0] - div_ff;
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         dvd_in  = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
         step_in = step_ff - STEP_WIDTH'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.found      = any_found_ff;
         rsp_in.last       = cmd.emit_last;
         rsp_in.prime_value = any_found_ff ? pending_ff : '0;
      end
      if (cmd.hold_prime) begin
         pending_in   = cand_ff;
         any_found_in = 1'b1;
         count_in     = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         any_found_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         any_found_ff <= any_found_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      limit_ff   <= limit_in;
      div_ff     <= div_in;
      sq_ff      <= sq_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      step_ff    <= step_in;
      pending_ff <= pending_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      sts.cand_in_range = (cand_ff < limit_ff);
      sts.cap_reached   = (count_ff == CAP_COUNT);
      sts.cand_small    = (cand_ff < FIRST_PRIME);
      sts.sq_gt_cand    = (sq_ff > {{VALUE_WIDTH{1'b0}}, cand_ff});
      sts.div_last      = (step_ff == '0);
      sts.rem_zero      = (rem_ff == '0);
      sts.any_found     = any_found_ff;
      sts.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> design/range_prime_finder_core.sv
// ----------------------------------------------------------------------------
// range_prime_finder_core
// Trial-division prime search over a half-open range, one prime per result, or one no-prime result if none.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req_      in    req_valid/req_ready    range_start, range_end
//  rsp_      out   rsp_valid/rsp_ready    prime_value, found, last
//
//  each trial divisor takes a square check, 16 remainder steps in the
//  bit-serial divider and a verdict
//  a new range is taken only once the search is finished; a result left
//  waiting in the output register does not block the next request
//  a stalled result stalls the search when the next prime is ready
//  synchronous reset clears control state only, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module range_prime_finder_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rpf_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rpf_pkg::rsp_type      rsp_payload
);
   import rpf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpf_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> design/rpf_checker.sv
// ----------------------------------------------------------------------------
// rpf_checker
// Port-level checks for range_prime_finder_core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire rpf_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rpf_pkg::rsp_type rsp_payload
);
   import rpf_pkg::*;

   // a stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // the no-prime result is always the only and final one
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.last && (rsp_payload.prime_value == '0))
      else $error("empty-range result malformed");

   // a reported prime is never below two
   a_prime_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |-> rsp_payload.prime_value >= FIRST_PRIME)
      else $error("reported prime below two");

   // the search is busy right after a request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while searching");

   // reset leaves no result pending
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind range_prime_finder_core rpf_checker u_rpf_checker (.*);

`default_nettype wire

>>> bench/range_prime_checker.sv
// ----------------------------------------------------------------------------
// range_prime_checker
// Watches both channels of the range prime finder. Each range transfer is
// expanded into the list of primes it should produce (trial division, span
// clipped, empty-range marker when none), and each result transfer is
// compared field by field against the oldest prime still outstanding.
// ----------------------------------------------------------------------------
module range_prime_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rpf_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rpf_pkg::rsp_type rsp_payload,
   output int unsigned      mismatch_count,
   output int unsigned      primes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import rpf_pkg::*;

   rsp_type expected_primes [$];

   initial begin
      mismatch_count     = 0;
      primes_outstanding = 0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic bit is_prime(input int unsigned n);
      int unsigned d;
      if (n < FIRST_PRIME) return 1'b0;
      for (d = FIRST_PRIME; d * d <= n; d++)
         if (n % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   task automatic predict_range(input req_type r);
      int unsigned lo;
      int unsigned hi;
      int unsigned c;
      int unsigned primes [$];
      rsp_type     item;
      lo = r.range_start;
      hi = r.range_end;
      if (hi > lo + MAX_SPAN) hi = lo + MAX_SPAN;
      for (c = lo; c < hi && primes.size() < RESULT_CAP; c++)
         if (is_prime(c)) primes = {primes, c};
      if (primes.size() == 0) begin
         item.prime_value = '0;
         item.found       = 1'b0;
         item.last        = 1'b1;
         expected_primes  = {expected_primes, item};
      end else begin
         foreach (primes[i]) begin
            item.prime_value = VALUE_WIDTH'(primes[i]);
            item.found       = 1'b1;
            item.last        = (i == primes.size() - 1);
            expected_primes  = {expected_primes, item};
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_primes.size() == 0) begin
               report_mismatch($sformatf("unexpected result value %0d found %0b last %0b",
                  rsp_payload.prime_value, rsp_payload.found, rsp_payload.last));
            end else begin
               want = expected_primes.pop_front();
               if (rsp_payload.prime_value !== want.prime_value)
                  report_mismatch($sformatf("prime_value %0d, wanted %0d",
                     rsp_payload.prime_value, want.prime_value));
               if (rsp_payload.found !== want.found)
                  report_mismatch($sformatf("found %0b, wanted %0b (value %0d)",
                     rsp_payload.found, want.found, want.prime_value));
               if (rsp_payload.last !== want.last)
                  report_mismatch($sformatf("last %0b, wanted %0b (value %0d)",
                     rsp_payload.last, want.last, want.prime_value));
            end
         end
         if (req_valid && req_ready) predict_range(req_payload);
      end
      primes_outstanding = expected_primes.size();
   end

endmodule

>>> bench/range_prime_finder_core_test.sv
// ----------------------------------------------------------------------------
// range_prime_finder_core_test
// Drives ranges into the prime finder: directed corner ranges first, then
// random ranges under several sender and receiver idling mixes, and a long
// receiver hold-off that backs the block up into its input. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module range_prime_finder_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rpf_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 25_000_000;
   localparam int unsigned HOLDOFF_CYCLES = 5000;
   localparam int unsigned PHASE_ITEMS    = 22;
   localparam int unsigned DRAIN_CYCLES   = 500;
   localparam int unsigned MAX_VALUE      = (1 << VALUE_WIDTH) - 1;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_payload;

   int unsigned mismatch_count;
   int unsigned primes_outstanding;
   int unsigned cycle_count   = 0;
   int unsigned idle_pct      = 0;
   int unsigned stall_pct     = 0;
   int unsigned holdoff_seq   = 0;
   int unsigned holdoff_taken = 0;
   int unsigned holdoff_left  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   range_prime_finder_core DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload
   );

   range_prime_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .mismatch_count, .primes_outstanding
   );

   // receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (holdoff_seq != holdoff_taken) begin
         holdoff_taken = holdoff_seq;
         holdoff_left  = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic offer_range(input logic [VALUE_WIDTH-1:0] lo, hi);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid               <= 1'b1;
      req_payload.range_start <= lo;
      req_payload.range_end   <= hi;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // mostly small values so trial division stays cheap
   task automatic offer_random_range();
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      pick = $urandom_range(99);
      if (pick < 55) begin
         lo = $urandom_range(400);
         hi = lo + $urandom_range(40);
      end else if (pick < 67) begin
         lo = $urandom_range(MAX_VALUE);
         hi = $urandom_range(lo);
      end else if (pick < 79) begin
         lo = $urandom_range(MAX_VALUE);
         hi = lo + $urandom_range(3);
      end else if (pick < 90) begin
         lo = $urandom_range(300);
         hi = lo + $urandom_range(400, 100);
      end else begin
         lo = $urandom_range(200);
         hi = $urandom_range(MAX_VALUE);
      end
      if (hi > MAX_VALUE) hi = MAX_VALUE;
      offer_range(VALUE_WIDTH'(lo), VALUE_WIDTH'(hi));
   endtask

   initial begin
      int unsigned n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer_range(16'd0, 16'd0);
      offer_range(16'd5, 16'd3);
      offer_range(16'd65535, 16'd65535);
      offer_range(16'd65535, 16'd0);
      offer_range(16'd0, 16'd2);
      offer_range(16'd1, 16'd2);
      offer_range(16'd0, 16'd3);
      offer_range(16'd2, 16'd3);
      offer_range(16'd4, 16'd5);
      offer_range(16'd24, 16'd29);
      offer_range(16'd97, 16'd98);
      offer_range(16'd0, 16'd65535);
      // 227 sits exactly at the clipped end, so it must not appear
      offer_range(16'd99, 16'd228);
      offer_range(16'd99, 16'd227);
      offer_range(16'd65521, 16'd65535);
      offer_range(16'd65400, 16'd65535);
      offer_range(16'h5555, 16'h555a);
      offer_range(16'haaaa, 16'haab0);
      offer_range(16'd32767, 16'd32772);

      for (int unsigned phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) offer_random_range();
      end

      // long hold-off while ranges with several primes keep coming
      idle_pct  = 0;
      stall_pct = 0;
      holdoff_seq++;
      for (n = 0; n < 8; n++) begin
         offer_range(VALUE_WIDTH'($urandom_range(200)),
                     VALUE_WIDTH'(200 + $urandom_range(60, 30)));
      end
      req_valid <= 1'b0;

      while (primes_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && primes_outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
design/rpf_pkg.sv
design/rpf_ctrl.sv
design/rpf_datapath.sv
design/range_prime_finder_core.sv
design/rpf_checker.sv
bench/range_prime_checker.sv
bench/range_prime_finder_core_test.sv
